### src/kas_pkg.sv
// Shared constants, types and command structs of the k-ary sketch block.
package kas_pkg;

  localparam int NUM_ROWS       = 5;
  localparam int HASHES_PER_ROW = 1;
  // ROW_WIDTH must be a power of two: the column is the low hash bits.
  localparam int ROW_WIDTH      = 1024;

  localparam int CELL_COUNT  = NUM_ROWS * ROW_WIDTH;
  localparam int PROBE_COUNT = NUM_ROWS * HASHES_PER_ROW;
  localparam int MEDIAN_RANK = PROBE_COUNT / 2;

  localparam int ADDR_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W   = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int HNUM_W  = (HASHES_PER_ROW > 1) ? $clog2(HASHES_PER_ROW) : 1;
  localparam int PROBE_W = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
  localparam int RANK_W  = $clog2(PROBE_COUNT + 1);

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic               load;
    logic               hash_init;
    logic               hash_byte;
    logic               hash_fin;
    logic               mem_rd;
    logic               mem_add;
    logic               keep_val;
    logic               clr_wr;
    logic               rank_en;
    logic               out_load;
    logic               lookup;
    logic [ROW_W-1:0]   row;
    logic [HNUM_W-1:0]  hnum;
    logic [1:0]         byte_idx;
    logic [PROBE_W-1:0] probe;
    logic [ADDR_W-1:0]  clr_addr;
  } kas_cmd_t;

endpackage

### src/kas_if.sv
// Valid/ready channel interfaces for requests and results.
interface kas_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] key;
  logic signed [63:0] add_value;
  modport source (output valid, req_type, key, add_value, input ready);
  modport sink (input valid, req_type, key, add_value, output ready);
endinterface

interface kas_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] estimate;
  logic        is_lookup;
  modport source (output valid, estimate, is_lookup, input ready);
  modport sink (input valid, estimate, is_lookup, output ready);
endinterface

### src/kas_datapath.sv
// Hash unit, counter memory, probe buffer, median rank unit and result register.
module kas_datapath (
  input  logic                clk,
  input  kas_pkg::kas_cmd_t   cmd,
  input  logic [31:0]         key_in,
  input  logic signed [63:0]  value_in,
  output logic [31:0]         estimate,
  output logic                is_lookup
);

  logic [31:0] key_q;
  logic [63:0] val_q;
  logic [31:0] word;
  logic [31:0] hash;
  logic [31:0] hash_next;
  logic [31:0] word_calc;
  logic [31:0] t_a;
  logic [31:0] t_b;
  logic [63:0] mem [kas_pkg::CELL_COUNT];
  logic [63:0] rdata;
  logic [kas_pkg::ADDR_W-1:0] addr;
  logic [63:0] vals [kas_pkg::PROBE_COUNT];
  logic [31:0] median;
  logic [kas_pkg::RANK_W-1:0] rank;
  logic [63:0] cand_val;

  assign word_calc = (key_q + 32'(cmd.row)) * 32'd7 + 32'(cmd.row) * 32'd13
                     + 32'(cmd.hnum) * 32'd31;

  always_comb begin
    t_a = '0;
    t_b = '0;
    hash_next = hash;
    if (cmd.hash_byte) begin
      t_a = hash + 32'(word[8*cmd.byte_idx +: 8]);
      t_b = t_a + (t_a << 10);
      hash_next = t_b ^ (t_b >> 6);
    end else if (cmd.hash_fin) begin
      t_a = hash + (hash << 3);
      t_b = t_a ^ (t_a >> 11);
      hash_next = t_b + (t_b << 15);
    end
  end

  assign addr = kas_pkg::ADDR_W'(cmd.row) * kas_pkg::ADDR_W'(kas_pkg::ROW_WIDTH)
                + kas_pkg::ADDR_W'(hash[kas_pkg::COL_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key_in;
      val_q <= value_in;
    end
    if (cmd.hash_init) begin
      word <= word_calc;
      hash <= '0;
    end else begin
      hash <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[cmd.clr_addr] <= '0;
    end else if (cmd.mem_add) begin
      mem[addr] <= rdata + val_q;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  assign cand_val = vals[cmd.probe];

  always_comb begin
    rank = '0;
    for (int j = 0; j < kas_pkg::PROBE_COUNT; j++) begin
      if ($signed(vals[j]) < $signed(cand_val) ||
          (vals[j] == cand_val && j < int'(cmd.probe))) begin
        rank = rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.keep_val) begin
      vals[cmd.probe] <= rdata;
    end
    if (cmd.rank_en && rank == kas_pkg::RANK_W'(kas_pkg::MEDIAN_RANK)) begin
      median <= cand_val[31:0];
    end
    if (cmd.out_load) begin
      estimate  <= cmd.lookup ? median : 32'd0;
      is_lookup <= cmd.lookup;
    end
  end

endmodule

### src/kas_ctrl.sv
// Request sequencer: probe, hash byte, clearing sweep and rank counters.
module kas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output kas_pkg::kas_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_HINIT = 4'd2;
  localparam logic [3:0] S_HBYTE = 4'd3;
  localparam logic [3:0] S_HFIN  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_RANK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                   state;
  logic [1:0]                   req;
  logic                         from_req;
  logic [kas_pkg::ROW_W-1:0]    row;
  logic [kas_pkg::HNUM_W-1:0]   hnum;
  logic [1:0]                   byte_idx;
  logic [kas_pkg::PROBE_W-1:0]  probe;
  logic [kas_pkg::ADDR_W-1:0]   clr_addr;
  logic                         accept;
  logic                         last_probe;

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign last_probe = (probe == kas_pkg::PROBE_W'(kas_pkg::PROBE_COUNT - 1));

  always_comb begin
    cmd           = '0;
    cmd.row       = row;
    cmd.hnum      = hnum;
    cmd.byte_idx  = byte_idx;
    cmd.probe     = probe;
    cmd.clr_addr  = clr_addr;
    cmd.lookup    = (req == kas_pkg::REQ_LOOKUP);
    cmd.load      = accept;
    cmd.hash_init = (state == S_HINIT);
    cmd.hash_byte = (state == S_HBYTE);
    cmd.hash_fin  = (state == S_HFIN);
    cmd.mem_rd    = (state == S_RD);
    cmd.mem_add   = (state == S_UPD) && (req == kas_pkg::REQ_ADD);
    cmd.keep_val  = (state == S_UPD) && (req == kas_pkg::REQ_LOOKUP);
    cmd.clr_wr    = (state == S_CLR);
    cmd.rank_en   = (state == S_RANK);
    cmd.out_load  = (state == S_DONE) && (!rsp_valid || rsp_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      from_req  <= 1'b0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
      req       <= kas_pkg::REQ_LOOKUP;
      row       <= '0;
      hnum      <= '0;
      byte_idx  <= '0;
      probe     <= '0;
    end else begin
      if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req      <= req_type;
            row      <= '0;
            hnum     <= '0;
            probe    <= '0;
            clr_addr <= '0;
            from_req <= 1'b1;
            case (req_type)
              kas_pkg::REQ_LOOKUP, kas_pkg::REQ_ADD: state <= S_HINIT;
              kas_pkg::REQ_CLEAR: state <= S_CLR;
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == kas_pkg::ADDR_W'(kas_pkg::CELL_COUNT - 1)) begin
            state <= from_req ? S_DONE : S_IDLE;
          end
        end
        S_HINIT: begin
          byte_idx <= '0;
          state    <= S_HBYTE;
        end
        S_HBYTE: begin
          byte_idx <= byte_idx + 1'b1;
          if (byte_idx == 2'd3) begin
            state <= S_HFIN;
          end
        end
        S_HFIN: state <= S_RD;
        S_RD: state <= S_UPD;
        S_UPD: begin
          if (last_probe) begin
            probe <= '0;
            state <= (req == kas_pkg::REQ_LOOKUP) ? S_RANK : S_DONE;
          end else begin
            probe <= probe + 1'b1;
            if (hnum == kas_pkg::HNUM_W'(kas_pkg::HASHES_PER_ROW - 1)) begin
              hnum <= '0;
              row  <= row + 1'b1;
            end else begin
              hnum <= hnum + 1'b1;
            end
            state <= S_HINIT;
          end
        end
        S_RANK: begin
          probe <= probe + 1'b1;
          if (last_probe) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/kary_sketch_update_median_query_core.sv
// Top level of the k-ary sketch with add, median lookup and clear requests.
// One request is handled at a time, and every request gives one result beat.
// Each of the NUM_ROWS*HASHES_PER_ROW probes runs word setup, four hash byte
// steps, hash finish, memory read and update in turn, because all counters
// share one single-port memory and the hash is computed one byte per cycle.
// A lookup adds one median rank step per probe after the last probe.
// A clear sweeps the memory one word per cycle.
// After reset the same sweep runs before the first request is taken.
module kary_sketch_update_median_query_core (
  input logic     clk,
  input logic     rst,
  kas_req_if.sink   req_ch,
  kas_rsp_if.source rsp_ch
);

  kas_pkg::kas_cmd_t cmd;

  kas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_type  (req_ch.req_type),
    .req_ready (req_ch.ready),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .cmd       (cmd)
  );

  kas_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .key_in    (req_ch.key),
    .value_in  (req_ch.add_value),
    .estimate  (rsp_ch.estimate),
    .is_lookup (rsp_ch.is_lookup)
  );

endmodule

### src/kas_checker.sv
// Port-level assertions for the sketch core and their bind.
module kas_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] estimate,
  input logic        is_lookup
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Request accepted while a request is in flight.");

  a_zero_unless_lookup: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_lookup |-> estimate == 32'd0)
    else $error("Non-lookup result carries a nonzero estimate.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_ready)
    else $error("Result or ready shown right after reset.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(estimate) && $stable(is_lookup))
    else $error("Stalled result beat changed.");

endmodule

bind kary_sketch_update_median_query_core kas_checker u_kas_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_ch.valid),
  .req_ready (req_ch.ready),
  .rsp_valid (rsp_ch.valid),
  .rsp_ready (rsp_ch.ready),
  .estimate  (rsp_ch.estimate),
  .is_lookup (rsp_ch.is_lookup)
);
